// ----- sv/acl_pkg.sv -----
// types, codes and helpers shared by the ipv4 access rule table
package acl_pkg;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] KIND_SUBNET = 2'd0;
  localparam logic [1:0] KIND_RANGE  = 2'd1;

  localparam logic [1:0] ST_INSERTED   = 2'd0;
  localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_LOOKUP     = 2'd3;

  localparam logic [5:0] MAX_PREFIX = 6'd32;

  typedef struct packed {
    logic        operation;
    logic [1:0]  rule_kind;
    logic [31:0] rule_address;
    logic [31:0] range_end;
    logic [5:0]  prefix_length;
    logic [15:0] rule_tag;
    logic [31:0] test_address;
    logic        address_present;
  } acl_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        allowed;
    logic        matched;
    logic [3:0]  matched_index;
    logic [15:0] matched_tag;
  } acl_result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] masked_base;
    logic [31:0] mask;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [15:0] tag;
  } acl_rule_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic        present;
    logic        found;
    logic [3:0]  index;
    logic [15:0] tag;
  } acl_token_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
    logic [5:0] sh;
    sh = MAX_PREFIX - plen;
    if (plen == 6'd0) begin
      return 32'h0;
    end
    return 32'hFFFF_FFFF << sh;
  endfunction

endpackage

// ----- sv/acl_cell.sv -----
// one rule cell: holds a rule and passes the lookup word to its neighbor
module acl_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  acl_pkg::acl_rule_t wr_rule,
  input  logic               live,
  input  logic [3:0]         cell_index,
  input  acl_pkg::acl_token_t tok_in,
  output acl_pkg::acl_token_t tok_out
);

  acl_pkg::acl_rule_t rule;
  logic               kind_hit;
  logic               hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule <= wr_rule;
    end
  end

  always_comb begin
    case (rule.kind)
      acl_pkg::KIND_SUBNET: kind_hit = (tok_in.addr & rule.mask) == rule.masked_base;
      acl_pkg::KIND_RANGE:  kind_hit = (tok_in.addr >= rule.lo) && (tok_in.addr <= rule.hi);
      default:              kind_hit = 1'b0;
    endcase
    hit = live && tok_in.present && kind_hit;
  end

  always_ff @(posedge clk) begin
    tok_out.addr    <= tok_in.addr;
    tok_out.present <= tok_in.present;
    tok_out.found   <= tok_in.found || hit;
    if (hit && !tok_in.found) begin
      tok_out.index <= cell_index;
      tok_out.tag   <= rule.tag;
    end else begin
      tok_out.index <= tok_in.index;
      tok_out.tag   <= tok_in.tag;
    end
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
  end

endmodule

// ----- sv/ipv4_acl_first_match.sv -----
// top level: ipv4 access rule table with first-match lookup
// append: result strobe in the cycle after start; busy stays low
// lookup on a non-empty table: the word walks the cell row, one cell a cycle,
//   the result is registered from the end of the row; busy is high until then
// lookup on an empty table: result in the cycle after start
// sync reset empties the table and sets the miss verdict to deny; results cannot be stalled
module ipv4_acl_first_match #(
  parameter int MAX_RULES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  acl_pkg::acl_req_t    req,
  output logic                 busy,
  output logic                 done,
  output acl_pkg::acl_result_t result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 miss_allow;
  logic                 running;
  logic                 running_next;
  logic                 done_next;
  acl_pkg::acl_result_t result_next;

  logic                 accept;
  logic                 is_lookup;
  logic                 full;
  logic                 bad_prefix;
  logic                 insert_ok;
  logic                 launch;
  acl_pkg::acl_rule_t   new_rule;
  logic [31:0]          new_mask;
  acl_pkg::acl_token_t  chain [MAX_RULES+1];

  // config only while no lookup is in the row
  assign cfg_ready = !running && !start;
  assign busy      = running;

  assign accept     = start && !busy;
  assign is_lookup  = req.operation == acl_pkg::OP_LOOKUP;
  assign full       = count == CNT_W'(MAX_RULES);
  assign bad_prefix = (req.rule_kind == acl_pkg::KIND_SUBNET) &&
                      (req.prefix_length > acl_pkg::MAX_PREFIX);
  assign insert_ok  = accept && !is_lookup && !full && !bad_prefix;
  assign launch     = accept && is_lookup && (count != '0);

  always_comb begin
    new_mask             = acl_pkg::prefix_mask(req.prefix_length);
    new_rule.kind        = req.rule_kind;
    new_rule.mask        = new_mask;
    new_rule.masked_base = req.rule_address & new_mask;
    new_rule.tag         = req.rule_tag;
    if (req.rule_address <= req.range_end) begin
      new_rule.lo = req.rule_address;
      new_rule.hi = req.range_end;
    end else begin
      new_rule.lo = req.range_end;
      new_rule.hi = req.rule_address;
    end
  end

  always_comb begin
    chain[0].valid   = launch;
    chain[0].addr    = req.test_address;
    chain[0].present = req.address_present;
    chain[0].found   = 1'b0;
    chain[0].index   = 4'd0;
    chain[0].tag     = 16'd0;
  end

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    acl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr_en      (insert_ok && (count == CNT_W'(i))),
      .wr_rule    (new_rule),
      .live       (count > CNT_W'(i)),
      .cell_index (4'(i % 16)),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1])
    );
  end

  always_comb begin
    count_next = count + CNT_W'(insert_ok);
    if (launch) begin
      running_next = 1'b1;
    end else if (chain[MAX_RULES].valid) begin
      running_next = 1'b0;
    end else begin
      running_next = running;
    end
  end

  always_comb begin
    done_next   = 1'b0;
    result_next = '0;
    if (chain[MAX_RULES].valid) begin
      done_next                 = 1'b1;
      result_next.status        = acl_pkg::ST_LOOKUP;
      result_next.matched       = chain[MAX_RULES].found;
      result_next.allowed       = chain[MAX_RULES].found || miss_allow;
      result_next.matched_index = chain[MAX_RULES].index;
      result_next.matched_tag   = chain[MAX_RULES].tag;
    end else if (accept) begin
      if (is_lookup) begin
        done_next           = !launch;
        result_next.status  = acl_pkg::ST_LOOKUP;
        result_next.allowed = 1'b1;
      end else begin
        done_next = 1'b1;
        if (full) begin
          result_next.status = acl_pkg::ST_FULL;
        end else if (bad_prefix) begin
          result_next.status = acl_pkg::ST_BAD_PREFIX;
        end else begin
          result_next.status = acl_pkg::ST_INSERTED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      count      <= '0;
      running    <= 1'b0;
      done       <= 1'b0;
      miss_allow <= 1'b0;
    end else begin
      count   <= count_next;
      running <= running_next;
      done    <= done_next;
      if (cfg_valid && cfg_ready) begin
        miss_allow <= cfg_data;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(chain[MAX_RULES].valid)))
    else $error("result strobe without a cause");

  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.operation == acl_pkg::OP_LOOKUP) && (count == '0))
      |=> (done && result.allowed))
    else $error("empty table lookup not allowed at once");

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RULES))
    else $error("rule count past table size");

  assert property (@(posedge clk) disable iff (rst)
    chain[MAX_RULES].valid |-> busy)
    else $error("lookup word left the row while idle");
`endif

endmodule

// ----- test/ipv4_acl_first_match_test.sv -----
// testbench for the ipv4 access rule table: directed rows, then random words with aimed lookup addresses, self-checked
module ipv4_acl_first_match_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int PHASE_WORDS = 500;
  localparam logic [1:0] KIND_NAME  = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  typedef struct packed {
    acl_pkg::acl_req_t    word;
    logic                 pinned;
    acl_pkg::acl_result_t want;
  } stim_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  acl_pkg::acl_req_t    req = '0;
  logic                 busy;
  logic                 done;
  acl_pkg::acl_result_t result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data = 1'b0;

  logic                 pin_valid = 1'b0;
  acl_pkg::acl_result_t pin_result = '0;

  logic [1:0]  kind_tab [TABLE_DEPTH];
  logic [31:0] base_tab [TABLE_DEPTH];
  logic [31:0] end_tab  [TABLE_DEPTH];
  logic [5:0]  plen_tab [TABLE_DEPTH];
  logic [15:0] tag_tab  [TABLE_DEPTH];
  int          table_size = 0;
  logic        policy = 1'b0;

  acl_pkg::acl_result_t verdict_q [$];
  int                   mismatch_count = 0;

  ipv4_acl_first_match #(.MAX_RULES(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [31:0] mask_of(input logic [5:0] plen);
    if (plen == 6'd0) begin
      return 32'h0;
    end
    return 32'hFFFF_FFFF << (32 - int'(plen));
  endfunction

  function automatic logic rule_covers(input int k, input logic [31:0] addr);
    logic [31:0] m;
    case (kind_tab[k])
      acl_pkg::KIND_SUBNET: begin
        m = mask_of(plen_tab[k]);
        return (addr & m) == (base_tab[k] & m);
      end
      acl_pkg::KIND_RANGE: begin
        return (addr >= base_tab[k] && addr <= end_tab[k]) ||
               (addr >= end_tab[k] && addr <= base_tab[k]);
      end
      default: return 1'b0;
    endcase
  endfunction

  // updates the rule table as the block does and returns the verdict
  function automatic acl_pkg::acl_result_t acl_decide(input acl_pkg::acl_req_t w);
    acl_pkg::acl_result_t r;
    r = '0;
    if (w.operation == acl_pkg::OP_APPEND) begin
      if (table_size == TABLE_DEPTH) begin
        r.status = acl_pkg::ST_FULL;
      end else if (w.rule_kind == acl_pkg::KIND_SUBNET &&
                   w.prefix_length > acl_pkg::MAX_PREFIX) begin
        r.status = acl_pkg::ST_BAD_PREFIX;
      end else begin
        kind_tab[table_size] = w.rule_kind;
        base_tab[table_size] = w.rule_address;
        end_tab[table_size]  = w.range_end;
        plen_tab[table_size] = w.prefix_length;
        tag_tab[table_size]  = w.rule_tag;
        table_size++;
        r.status = acl_pkg::ST_INSERTED;
      end
      return r;
    end
    r.status = acl_pkg::ST_LOOKUP;
    if (table_size == 0) begin
      r.allowed = 1'b1;
      return r;
    end
    if (w.address_present) begin
      for (int k = 0; k < table_size; k++) begin
        if (rule_covers(k, w.test_address)) begin
          r.allowed = 1'b1;
          r.matched = 1'b1;
          r.matched_index = 4'(k);
          r.matched_tag = tag_tab[k];
          return r;
        end
      end
    end
    r.allowed = policy;
    return r;
  endfunction

  // mostly addresses inside stored rules or at or just past their edges
  function automatic logic [31:0] aimed_address();
    int k;
    logic [31:0] m, lo, hi, a;
    logic [32:0] span;
    if (table_size == 0 || $urandom_range(3) == 0) begin
      return $urandom();
    end
    k = $urandom_range(table_size - 1);
    a = $urandom();
    case (kind_tab[k])
      acl_pkg::KIND_SUBNET: begin
        m = mask_of(plen_tab[k]);
        a = (base_tab[k] & m) | (a & ~m);
        if (plen_tab[k] != 6'd0 && plen_tab[k] <= acl_pkg::MAX_PREFIX &&
            $urandom_range(3) == 0) begin
          a = a ^ (32'h1 << (32 - int'(plen_tab[k])));
        end
      end
      acl_pkg::KIND_RANGE: begin
        lo = (base_tab[k] < end_tab[k]) ? base_tab[k] : end_tab[k];
        hi = (base_tab[k] < end_tab[k]) ? end_tab[k] : base_tab[k];
        span = {1'b0, hi} - {1'b0, lo} + 33'd1;
        case ($urandom_range(4))
          0: a = lo;
          1: a = hi;
          2: a = lo - 32'd1;
          3: a = hi + 32'd1;
          default: a = lo + 32'({1'b0, a} % span);
        endcase
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic acl_pkg::acl_req_t random_word();
    acl_pkg::acl_req_t w;
    w.operation       = ($urandom_range(99) < 10) ? acl_pkg::OP_APPEND : acl_pkg::OP_LOOKUP;
    w.rule_kind       = 2'($urandom_range(3));
    w.rule_address    = $urandom();
    w.range_end       = $urandom();
    w.prefix_length   = 6'($urandom_range(63));
    w.rule_tag        = 16'($urandom());
    w.test_address    = aimed_address();
    w.address_present = ($urandom_range(99) < 85);
    return w;
  endfunction

  function automatic stim_row_t rule_row(input logic [1:0] kind, input logic [31:0] a,
                                         input logic [31:0] b, input logic [5:0] plen,
                                         input logic [15:0] tag, input logic [1:0] st);
    stim_row_t r;
    r = '0;
    r.word.operation     = acl_pkg::OP_APPEND;
    r.word.rule_kind     = kind;
    r.word.rule_address  = a;
    r.word.range_end     = b;
    r.word.prefix_length = plen;
    r.word.rule_tag      = tag;
    r.pinned             = 1'b1;
    r.want.status        = st;
    return r;
  endfunction

  function automatic stim_row_t lookup_row(input logic [31:0] addr, input logic present,
                                           input logic pinned, input logic allowed);
    stim_row_t r;
    r = '0;
    r.word.operation       = acl_pkg::OP_LOOKUP;
    r.word.test_address    = addr;
    r.word.address_present = present;
    r.pinned               = pinned;
    r.want.status          = acl_pkg::ST_LOOKUP;
    r.want.allowed         = allowed;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 50) begin
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : scoreboard
    acl_pkg::acl_result_t want, predicted;
    if (rst === 1'b0) begin
      if (done === 1'b1) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected word", 32'(result), 32'h0);
        end else begin
          want = verdict_q.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", 32'(result.status), 32'(want.status));
          if (result.allowed !== want.allowed)
            report_mismatch("allowed", 32'(result.allowed), 32'(want.allowed));
          if (result.matched !== want.matched)
            report_mismatch("matched", 32'(result.matched), 32'(want.matched));
          if (result.matched_index !== want.matched_index)
            report_mismatch("matched_index", 32'(result.matched_index),
                            32'(want.matched_index));
          if (result.matched_tag !== want.matched_tag)
            report_mismatch("matched_tag", 32'(result.matched_tag), 32'(want.matched_tag));
        end
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        policy = cfg_data;
      end
      if (start && busy === 1'b0) begin
        predicted = acl_decide(req);
        verdict_q.push_back(pin_valid ? pin_result : predicted);
      end
    end
  end

  task automatic send_word(input acl_pkg::acl_req_t w, input logic pinned,
                           input acl_pkg::acl_result_t want, input logic may_idle);
    if (may_idle && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    start      <= 1'b1;
    req        <= w;
    pin_valid  <= pinned;
    pin_result <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_policy(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    stim_row_t rows [$];
    logic phase_policy;

    // empty table, bad prefixes, then a mix of rule kinds
    rows.push_back(lookup_row(32'h0000_0000, 1'b1, 1'b1, 1'b1));
    rows.push_back(lookup_row(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1));
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'h0A00_0000, 32'h0, 6'd33, 16'h0001,
                            acl_pkg::ST_BAD_PREFIX));
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63,
                            16'hFFFF, acl_pkg::ST_BAD_PREFIX));
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'h0A00_0000, 32'h0, 6'd8, 16'h0001,
                            acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(acl_pkg::KIND_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FF00, 6'd0,
                            16'hFFFF, acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(KIND_NAME, 32'h0, 32'h0, 6'd63, 16'h0002,
                            acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(KIND_OTHER, 32'hC0A8_0101, 32'h0, 6'd32, 16'h0003,
                            acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(acl_pkg::KIND_RANGE, 32'h0, 32'h0, 6'd63, 16'h0004,
                            acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'hC0A8_0101, 32'h0, 6'd32, 16'h0005,
                            acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'h8000_0000, 32'h0, 6'd1, 16'h0006,
                            acl_pkg::ST_INSERTED));
    rows.push_back(lookup_row(32'h0A01_0203, 1'b1, 1'b0, 1'b0));
    rows.push_back(lookup_row(32'hFFFF_FF80, 1'b1, 1'b0, 1'b0));
    rows.push_back(lookup_row(32'hC0A8_0101, 1'b1, 1'b0, 1'b0));
    rows.push_back(lookup_row(32'h0000_0000, 1'b1, 1'b0, 1'b0));
    rows.push_back(lookup_row(32'h0A00_0000, 1'b0, 1'b1, 1'b0));
    rows.push_back(lookup_row(32'h1234_5678, 1'b1, 1'b1, 1'b0));
    rows.push_back(rule_row(acl_pkg::KIND_RANGE, 32'h7FFF_FFFF, 32'h8000_0000, 6'd5,
                            16'h0008, acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'hAC10_0000, 32'h0, 6'd12, 16'h0009,
                            acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'h0000_0001, 32'h0, 6'd31, 16'h000A,
                            acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'h6400_0000, 32'h0, 6'd24, 16'h000B,
                            acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(acl_pkg::KIND_RANGE, 32'h0000_1000, 32'h0000_FFFF, 6'd0,
                            16'h000C, acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'hC000_0000, 32'h0, 6'd2, 16'h000D,
                            acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'hFFFF_0000, 32'h0, 6'd16, 16'h000E,
                            acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(KIND_NAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 16'h000F,
                            acl_pkg::ST_INSERTED));
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'hDEAD_BEEF, 32'h0, 6'd0, 16'h00F0,
                            acl_pkg::ST_INSERTED));
    // table is full now; full wins over a bad prefix
    rows.push_back(rule_row(acl_pkg::KIND_SUBNET, 32'h0, 32'h0, 6'd40, 16'h0100,
                            acl_pkg::ST_FULL));
    rows.push_back(rule_row(acl_pkg::KIND_RANGE, 32'h1, 32'h2, 6'd0, 16'h0101,
                            acl_pkg::ST_FULL));
    rows.push_back(lookup_row(32'h1234_5678, 1'b1, 1'b0, 1'b0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_word(rows[i].word, rows[i].pinned, rows[i].want, 1'b1);
    end

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      phase_policy = (phase < 2) ? ~phase[0] : 1'($urandom_range(1));
      write_policy(phase_policy);
      repeat (PHASE_WORDS) begin
        send_word(random_word(), 1'b0, '0, phase != 1);
      end
    end

    settle();
    repeat (TABLE_DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/acl_pkg.sv
sv/acl_cell.sv
sv/ipv4_acl_first_match.sv
test/ipv4_acl_first_match_test.sv
